// File: hw/rtl/frustum_cull_test_defines.svh
// Assertion macros for the frustum cull test RTL.
// Depends on nothing; files that assert include it by name.
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

`ifndef SYNTHESIS
// Checked while the block is out of reset.
`define FCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked at every edge, including those in reset.
`define FCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define FCT_ASSERT(lbl, prop, msg)
`define FCT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/fct_pkg.sv
// Types, constants and helpers for the frustum cull test block.
// Used by fct_regs, fct_cell and frustum_cull_test; depends on nothing.
package fct_pkg;

    localparam int NUM_PLANES  = 6;
    localparam int PLANE_REGS  = 6;
    localparam int NUM_CELLS   = (NUM_PLANES < PLANE_REGS) ? NUM_PLANES : PLANE_REGS;
    localparam int COORD_WIDTH = 16;
    localparam int SIZE_WIDTH  = 15;
    localparam int NORM_WIDTH  = 16;
    localparam int FRAC_BITS   = 14;
    localparam int REG_WIDTH   = 64;

    // Plane register layout.
    localparam int NX_LSB = 48;
    localparam int NY_LSB = 32;
    localparam int NZ_LSB = 16;
    localparam int D_LSB  = 0;

    // APB address decode: registers on 8-byte boundaries.
    localparam int REG_IDX_W = $clog2(PLANE_REGS);
    localparam int ADDR_W    = REG_IDX_W + 3;

    // Arithmetic widths.
    localparam int PROD_W  = COORD_WIDTH + NORM_WIDTH;
    localparam int RPROD_W = NORM_WIDTH + SIZE_WIDTH;
    localparam int DIST_W  = PROD_W + 2;
    localparam int RAD_W   = RPROD_W + 2;
    localparam int CMP_W   = ((DIST_W > RAD_W) ? DIST_W : RAD_W) + 1;

    // Stream packing.
    localparam int S_TDATA_W = ((3 * COORD_WIDTH + 3 * SIZE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    typedef enum logic [1:0] {
        VERDICT_INSIDE     = 2'd0,
        VERDICT_INTERSECTS = 2'd1,
        VERDICT_OUTSIDE    = 2'd2
    } verdict_t;

    typedef logic [REG_WIDTH-1:0] plane_t;

    // One request as it travels down the chain, with its running verdict.
    typedef struct packed {
        logic                          cmd;
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] center_z;
        logic [SIZE_WIDTH-1:0]         size_x;
        logic [SIZE_WIDTH-1:0]         size_y;
        logic [SIZE_WIDTH-1:0]         size_z;
        verdict_t                      verdict;
    } item_t;

    // Magnitude of a Q1.14 normal component; the most negative code gives 2^15.
    function automatic logic [NORM_WIDTH-1:0] norm_mag(input logic signed [NORM_WIDTH-1:0] n);
        logic [NORM_WIDTH-1:0] m;
        m = n[NORM_WIDTH-1] ? NORM_WIDTH'(-n) : NORM_WIDTH'(n);
        return m;
    endfunction

endpackage

// File: hw/rtl/fct_regs.sv
// APB register file holding the six frustum planes.
// Depends on fct_pkg.
module fct_regs
    import fct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [REG_WIDTH-1:0]  pwdata,
    output logic [REG_WIDTH-1:0]  prdata,
    output logic                  pready,
    output plane_t                planes [PLANE_REGS]
);

    plane_t               plane_reg [PLANE_REGS];
    logic [REG_IDX_W-1:0] idx;
    logic                 idx_ok;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:3];
    assign idx_ok = ({1'b0, idx} < (REG_IDX_W + 1)'(PLANE_REGS));
    assign wr_en  = psel && penable && pwrite && pready && idx_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PLANE_REGS; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (wr_en) begin
            plane_reg[idx] <= pwdata;
        end
    end

    // Reads outside the register list return zero.
    always_comb begin
        prdata = '0;
        if (idx_ok) begin
            prdata = plane_reg[idx];
        end
    end

    assign planes = plane_reg;

endmodule

// File: hw/rtl/fct_cell.sv
// One link of the culling chain: tests a request against one plane in two stages.
// Depends on fct_pkg and frustum_cull_test_defines.svh.
`include "frustum_cull_test_defines.svh"

module fct_cell
    import fct_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  plane_t plane,
    input  logic   in_valid,
    output logic   in_ready,
    input  item_t  in_item,
    output logic   out_valid,
    input  logic   out_ready,
    output item_t  out_item
);

    logic signed [NORM_WIDTH-1:0] nx, ny, nz, d;

    // Stage A: products.
    logic                      a_valid_reg, a_valid_next;
    item_t                     a_item_reg;
    logic signed [PROD_W-1:0]  px_reg, py_reg, pz_reg;
    logic [RPROD_W-1:0]        rx_reg, ry_reg, rz_reg;
    logic                      a_ready;
    logic                      a_load;

    // Stage B: sums, compare and verdict update.
    logic                      b_valid_reg, b_valid_next;
    item_t                     b_item_reg, b_item_next;
    logic                      b_ready;
    logic                      b_load;

    logic signed [CMP_W-1:0]   plane_dist;
    logic [RAD_W-1:0]          rad;
    logic signed [CMP_W-1:0]   rad_s;

    assign nx = plane[NX_LSB +: NORM_WIDTH];
    assign ny = plane[NY_LSB +: NORM_WIDTH];
    assign nz = plane[NZ_LSB +: NORM_WIDTH];
    assign d  = plane[D_LSB  +: NORM_WIDTH];

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;
    assign a_load   = in_valid && a_ready;
    assign b_load   = a_valid_reg && b_ready;

    assign a_valid_next = a_ready ? in_valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_item_reg <= in_item;
            px_reg     <= PROD_W'(nx) * PROD_W'(in_item.center_x);
            py_reg     <= PROD_W'(ny) * PROD_W'(in_item.center_y);
            pz_reg     <= PROD_W'(nz) * PROD_W'(in_item.center_z);
            rx_reg     <= RPROD_W'(norm_mag(nx)) * RPROD_W'(in_item.size_x);
            ry_reg     <= RPROD_W'(norm_mag(ny)) * RPROD_W'(in_item.size_y);
            rz_reg     <= RPROD_W'(norm_mag(nz)) * RPROD_W'(in_item.size_z);
        end
        if (b_load) begin
            b_item_reg <= b_item_next;
        end
    end

    always_comb begin
        plane_dist = CMP_W'(px_reg) + CMP_W'(py_reg) + CMP_W'(pz_reg)
                   + (CMP_W'(d) <<< FRAC_BITS);
        if (a_item_reg.cmd) begin
            rad = RAD_W'(rx_reg) + RAD_W'(ry_reg) + RAD_W'(rz_reg);
        end else begin
            rad = RAD_W'(a_item_reg.size_x) << FRAC_BITS;
        end
        rad_s = signed'(CMP_W'(rad));

        // Once a plane rejects the volume, later planes leave it rejected.
        b_item_next = a_item_reg;
        if (a_item_reg.verdict != VERDICT_OUTSIDE) begin
            if (plane_dist <= -rad_s) begin
                b_item_next.verdict = VERDICT_OUTSIDE;
            end else if (plane_dist <= rad_s) begin
                b_item_next.verdict = VERDICT_INTERSECTS;
            end
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

    `FCT_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !a_valid_reg && !b_valid_reg, "cell stages not cleared by reset")
    `FCT_ASSERT(a_outside_sticks, b_load && a_item_reg.verdict == VERDICT_OUTSIDE |=> b_item_reg.verdict == VERDICT_OUTSIDE, "outside verdict lost in cell")
    `FCT_ASSERT(a_verdict_code, b_valid_reg |-> b_item_reg.verdict != 2'd3, "undefined verdict code in cell")

endmodule

// File: hw/rtl/frustum_cull_test.sv
// Top level of the frustum cull test: APB plane registers and a chain of plane cells.
// Depends on fct_pkg, fct_regs and fct_cell.
//
//  Channel   Direction  Handshake                Payload
//  s_axis    in         tvalid/tready            tdata: centers, sizes; tuser: cmd
//  m_axis    out        tvalid/tready            tdata: verdict
//  apb       in         psel/penable/pready      64-bit plane registers at 8*i
//
// One request enters per cycle while the chain is not stalled; each plane cell holds it
// in stage A (products), then in stage B (sums and compare), before passing it on.
// Reset is synchronous and active low; it clears the plane registers and all stage valids.
// Every stage has its own ready, so a stalled output only holds the stages that are full,
// and empty stages further up keep taking requests.
module frustum_cull_test
    import fct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Request stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata from bit 0: center_x, center_y, center_z, size_x, size_y, size_z, zero fill
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: cmd (0 sphere, 1 axis-aligned box)
    input  logic                  s_axis_tuser,
    // Verdict stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata from bit 0: verdict (2 bits), zero fill
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // Plane register port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [REG_WIDTH-1:0]  pwdata,
    output logic [REG_WIDTH-1:0]  prdata,
    output logic                  pready
);

    localparam int CY_LSB = COORD_WIDTH;
    localparam int CZ_LSB = 2 * COORD_WIDTH;
    localparam int SX_LSB = 3 * COORD_WIDTH;
    localparam int SY_LSB = SX_LSB + SIZE_WIDTH;
    localparam int SZ_LSB = SY_LSB + SIZE_WIDTH;

    plane_t planes [PLANE_REGS];

    logic  link_valid [NUM_CELLS+1];
    logic  link_ready [NUM_CELLS+1];
    item_t link_item  [NUM_CELLS+1];

    fct_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    // Unpack the request; every volume starts as inside and the cells refine it.
    always_comb begin
        link_item[0].cmd      = s_axis_tuser;
        link_item[0].center_x = s_axis_tdata[0 +: COORD_WIDTH];
        link_item[0].center_y = s_axis_tdata[CY_LSB +: COORD_WIDTH];
        link_item[0].center_z = s_axis_tdata[CZ_LSB +: COORD_WIDTH];
        link_item[0].size_x   = s_axis_tdata[SX_LSB +: SIZE_WIDTH];
        link_item[0].size_y   = s_axis_tdata[SY_LSB +: SIZE_WIDTH];
        link_item[0].size_z   = s_axis_tdata[SZ_LSB +: SIZE_WIDTH];
        link_item[0].verdict  = VERDICT_INSIDE;
    end

    assign link_valid[0] = s_axis_tvalid;
    assign s_axis_tready = link_ready[0];

    // Cell p tests plane p, in register order.
    for (genvar p = 0; p < NUM_CELLS; p++) begin : g_cell
        fct_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .plane     (planes[p]),
            .in_valid  (link_valid[p]),
            .in_ready  (link_ready[p]),
            .in_item   (link_item[p]),
            .out_valid (link_valid[p+1]),
            .out_ready (link_ready[p+1]),
            .out_item  (link_item[p+1])
        );
    end

    assign link_ready[NUM_CELLS] = m_axis_tready;
    assign m_axis_tvalid         = link_valid[NUM_CELLS];
    assign m_axis_tdata          = M_TDATA_W'(link_item[NUM_CELLS].verdict);

endmodule

// File: tb/cull_verdict_monitor.sv
`timescale 1ns / 1ps
// Verdict monitor for the frustum cull block. It watches the request, verdict and APB ports,
// keeps its own copy of the plane registers and checks each verdict in order. Depends on fct_pkg.
module cull_verdict_monitor
    import fct_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // tdata from bit 0: center_x, center_y, center_z, size_x, size_y, size_z, zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // tuser: cmd (0 sphere, 1 axis-aligned box)
    input  logic                 s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata from bit 0: verdict (2 bits), zero fill
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [REG_WIDTH-1:0] pwdata,
    output int                   mismatch_count,
    output int                   verdicts_pending,
    output int                   inside_seen,
    output int                   intersects_seen,
    output int                   outside_seen
);

    plane_t   plane_copy [PLANE_REGS];
    verdict_t expected_verdicts [$];
    int       n_fail;
    int       n_inside;
    int       n_intersects;
    int       n_outside;

    // Exact test of one volume against every live plane, all values at scale 2^14.
    function automatic verdict_t classify_volume(
        input logic                          is_box,
        input logic signed [COORD_WIDTH-1:0] cx,
        input logic signed [COORD_WIDTH-1:0] cy,
        input logic signed [COORD_WIDTH-1:0] cz,
        input logic [SIZE_WIDTH-1:0]         ex,
        input logic [SIZE_WIDTH-1:0]         ey,
        input logic [SIZE_WIDTH-1:0]         ez
    );
        verdict_t result;
        longint   nx, ny, nz, d, plane_dist, radius;
        longint   hx, hy, hz;
        result = VERDICT_INSIDE;
        hx = ex;
        hy = ey;
        hz = ez;
        for (int p = 0; p < NUM_CELLS; p++) begin
            if (result != VERDICT_OUTSIDE) begin
                nx = $signed(plane_copy[p][NX_LSB +: NORM_WIDTH]);
                ny = $signed(plane_copy[p][NY_LSB +: NORM_WIDTH]);
                nz = $signed(plane_copy[p][NZ_LSB +: NORM_WIDTH]);
                d  = $signed(plane_copy[p][D_LSB +: COORD_WIDTH]);
                plane_dist = nx * cx + ny * cy + nz * cz + d * (longint'(1) << FRAC_BITS);
                if (is_box) begin
                    // Magnitudes in 64 bits, so the most negative code counts as 2^15.
                    radius = (nx < 0 ? -nx : nx) * hx + (ny < 0 ? -ny : ny) * hy
                           + (nz < 0 ? -nz : nz) * hz;
                end else begin
                    radius = hx * (longint'(1) << FRAC_BITS);
                end
                if (plane_dist <= -radius) begin
                    result = VERDICT_OUTSIDE;
                end else if (plane_dist <= radius) begin
                    result = VERDICT_INTERSECTS;
                end
            end
        end
        return result;
    endfunction

    always @(posedge aclk) begin : watch
        verdict_t want;
        verdict_t got;
        if (!aresetn) begin
            foreach (plane_copy[i]) plane_copy[i] = '0;
            expected_verdicts.delete();
            n_fail       = 0;
            n_inside     = 0;
            n_intersects = 0;
            n_outside    = 0;
        end else begin
            // Writes to the two unmapped slots are dropped by the block as well.
            if (psel && penable && pwrite && pready && paddr[ADDR_W-1:3] < PLANE_REGS) begin
                plane_copy[paddr[ADDR_W-1:3]] = pwdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_verdicts.push_back(classify_volume(
                    s_axis_tuser,
                    s_axis_tdata[0 +: COORD_WIDTH],
                    s_axis_tdata[COORD_WIDTH +: COORD_WIDTH],
                    s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH],
                    s_axis_tdata[3*COORD_WIDTH +: SIZE_WIDTH],
                    s_axis_tdata[3*COORD_WIDTH + SIZE_WIDTH +: SIZE_WIDTH],
                    s_axis_tdata[3*COORD_WIDTH + 2*SIZE_WIDTH +: SIZE_WIDTH]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = verdict_t'(m_axis_tdata[1:0]);
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: verdict with no request waiting, expected none, actual %0d",
                             $time, m_axis_tdata[1:0]);
                    n_fail++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got !== want) begin
                        $display("%0t: verdict mismatch, expected %0d (%s), actual %0d",
                                 $time, want, want.name(), m_axis_tdata[1:0]);
                        n_fail++;
                    end
                    case (got)
                        VERDICT_INSIDE:     n_inside++;
                        VERDICT_INTERSECTS: n_intersects++;
                        VERDICT_OUTSIDE:    n_outside++;
                        default: ;
                    endcase
                end
            end
        end
        mismatch_count   <= n_fail;
        verdicts_pending <= expected_verdicts.size();
        inside_seen      <= n_inside;
        intersects_seen  <= n_intersects;
        outside_seen     <= n_outside;
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the frustum cull testbench: clock, reset, request and plane stimulus, and the verdict.
// Depends on fct_pkg, frustum_cull_test and cull_verdict_monitor.
module testbench
    import fct_pkg::*;
();

    // Volume kinds as carried on tuser.
    localparam logic CMD_SPHERE = 1'b0;
    localparam logic CMD_BOX    = 1'b1;

    // Plane register slots, plus the two addresses the decode leaves unmapped.
    localparam int PLANE_LEFT   = 0;
    localparam int PLANE_RIGHT  = 1;
    localparam int PLANE_BOTTOM = 2;
    localparam int PLANE_TOP    = 3;
    localparam int PLANE_NEAR   = 4;
    localparam int PLANE_FAR    = 5;
    localparam int UNMAPPED_LO  = 6;
    localparam int UNMAPPED_HI  = 7;

    localparam int UNIT_NORMAL = 1 << FRAC_BITS;
    localparam int HOLD_CYCLES = 300;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [REG_WIDTH-1:0] pwdata;
    logic [REG_WIDTH-1:0] prdata;
    logic                 pready;

    int mismatch_count;
    int verdicts_pending;
    int inside_seen;
    int intersects_seen;
    int outside_seen;

    int requests_sent;
    int settings_loaded;
    int burst_left;
    bit hold_request;

    frustum_cull_test dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    cull_verdict_monitor monitor (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .mismatch_count   (mismatch_count),
        .verdicts_pending (verdicts_pending),
        .inside_seen      (inside_seen),
        .intersects_seen  (intersects_seen),
        .outside_seen     (outside_seen)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Packs one plane register: nx in the top bits, then ny, nz and the offset d.
    function automatic plane_t plane_word(input int nx, input int ny, input int nz, input int d);
        return {nx[15:0], ny[15:0], nz[15:0], d[15:0]};
    endfunction

    // One APB write: a setup cycle, then an access cycle that completes on pready.
    task automatic apb_write(input int index, input plane_t value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(index * 8);
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one request and returns at the edge where the block takes it.
    task automatic send_volume(input logic cmd, input int cx, input int cy, input int cz,
                               input int sx, input int sy, input int sz);
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= S_TDATA_W'({sz[SIZE_WIDTH-1:0], sy[SIZE_WIDTH-1:0], sx[SIZE_WIDTH-1:0],
                                     cz[COORD_WIDTH-1:0], cy[COORD_WIDTH-1:0],
                                     cx[COORD_WIDTH-1:0]});
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        requests_sent++;
    endtask

    // Drops tvalid for a number of cycles; the data lines carry noise meanwhile.
    task automatic pause_requests(input int cycles);
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= S_TDATA_W'({$urandom, $urandom, $urandom});
        s_axis_tuser  <= 1'($urandom_range(0, 1));
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // Bursts of random length with random gaps; many gaps are zero, so bursts often merge.
    task automatic pace_requests();
        int pick;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                gap = 0;
            end else if (pick < 9) begin
                gap = $urandom_range(1, 4);
            end else begin
                gap = $urandom_range(5, 30);
            end
            if (gap > 0) pause_requests(gap);
        end
        burst_left--;
    endtask

    // Waits until every verdict is in, then lets the pipeline empty before registers change.
    task automatic settle_verdicts();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_pending != 0) @(posedge aclk);
        repeat (2 * NUM_CELLS + 4) @(posedge aclk);
    endtask

    // An axis-aligned cube of half width w with exact unit normals.
    task automatic load_cube(input int w);
        apb_write(PLANE_LEFT,   plane_word( UNIT_NORMAL, 0, 0, w));
        apb_write(PLANE_RIGHT,  plane_word(-UNIT_NORMAL, 0, 0, w));
        apb_write(PLANE_BOTTOM, plane_word(0,  UNIT_NORMAL, 0, w));
        apb_write(PLANE_TOP,    plane_word(0, -UNIT_NORMAL, 0, w));
        apb_write(PLANE_NEAR,   plane_word(0, 0,  UNIT_NORMAL, w));
        apb_write(PLANE_FAR,    plane_word(0, 0, -UNIT_NORMAL, w));
        settings_loaded++;
    endtask

    // A skewed box frustum: each plane faces inward along its axis, tilted by up to tilt,
    // with a slightly shortened normal and an offset near w.
    task automatic load_frustum(input int w, input int tilt);
        int comp [3];
        int main_axis;
        for (int p = 0; p < PLANE_REGS; p++) begin
            for (int a = 0; a < 3; a++) comp[a] = int'($urandom_range(0, 2 * tilt)) - tilt;
            main_axis = int'($urandom_range(12000, UNIT_NORMAL));
            comp[p / 2] = (p % 2 == 0) ? main_axis : -main_axis;
            apb_write(p, plane_word(comp[0], comp[1], comp[2],
                                    w - int'($urandom_range(0, w / 4))));
        end
        settings_loaded++;
    endtask

    task automatic load_uniform(input plane_t value);
        for (int p = 0; p < PLANE_REGS; p++) apb_write(p, value);
        settings_loaded++;
    endtask

    // Most requests sit around the frustum of half width w so that all three verdicts
    // come up; the rest use the full range of every field.
    task automatic send_random_volumes(input int count, input int w, input bit paced);
        int span;
        int pick;
        int cx, cy, cz, sx, sy, sz;
        span = (2 * w > 32767) ? 32767 : 2 * w;
        repeat (count) begin
            if ($urandom_range(0, 99) < 15) begin
                cx = int'($urandom_range(0, 65535)) - 32768;
                cy = int'($urandom_range(0, 65535)) - 32768;
                cz = int'($urandom_range(0, 65535)) - 32768;
                sx = $urandom_range(0, 32767);
                sy = $urandom_range(0, 32767);
                sz = $urandom_range(0, 32767);
            end else begin
                cx = int'($urandom_range(0, 2 * span)) - span;
                cy = int'($urandom_range(0, 2 * span)) - span;
                cz = int'($urandom_range(0, 2 * span)) - span;
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    sx = $urandom_range(0, w / 8);
                    sy = $urandom_range(0, w / 8);
                    sz = $urandom_range(0, w / 8);
                end else if (pick < 9) begin
                    sx = $urandom_range(0, w);
                    sy = $urandom_range(0, w);
                    sz = $urandom_range(0, w);
                end else begin
                    sx = $urandom_range(0, 32767);
                    sy = $urandom_range(0, 32767);
                    sz = $urandom_range(0, 32767);
                end
            end
            if (paced) pace_requests();
            send_volume(1'($urandom_range(0, 1)), cx, cy, cz, sx, sy, sz);
        end
    endtask

    // Verdict receiver. It changes its stall pattern at random points: always ready,
    // coin flips, mostly ready, or ready when a tick counter is a multiple of three. On the
    // first hold-off request it stays low for a stretch set by HOLD_CYCLES, so the block backs up.
    initial begin
        int rx_mode;
        int mode_left;
        int tick;
        bit hold_taken;
        m_axis_tready = 1'b0;
        rx_mode    = 0;
        mode_left  = 0;
        tick       = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default: m_axis_tready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // Stimulus: directed corner cases first, then random phases under several plane sets.
    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_request  = 1'b0;
        requests_sent   = 0;
        settings_loaded = 1;
        burst_left      = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // All planes are zero after reset: distance is zero everywhere, so a zero radius
        // is outside and any other radius intersects. A box has zero radius here.
        send_volume(CMD_SPHERE, 0, 0, 0, 0, 0, 0);
        send_volume(CMD_SPHERE, -32768, 32767, 0, 1, 0, 0);
        send_volume(CMD_BOX, 32767, -32768, -1, 32767, 32767, 32767);
        send_volume(CMD_SPHERE, 0, 0, 0, 32767, 0, 0);
        settle_verdicts();

        // Writes to the unmapped slots must leave the planes untouched.
        apb_write(UNMAPPED_LO, '1);
        apb_write(UNMAPPED_HI, plane_word(UNIT_NORMAL, UNIT_NORMAL, UNIT_NORMAL, 100));
        send_volume(CMD_SPHERE, 5, 5, 5, 0, 0, 0);
        settle_verdicts();

        // Unit cube of half width 1000: exact boundary hits on the left and right planes.
        load_cube(1000);
        send_volume(CMD_SPHERE, 0, 0, 0, 10, 0, 0);
        send_volume(CMD_SPHERE, 1000, 0, 0, 0, 0, 0);
        send_volume(CMD_SPHERE, 999, 0, 0, 1, 0, 0);
        send_volume(CMD_SPHERE, 1001, 0, 0, 1, 0, 0);
        send_volume(CMD_BOX, 0, 0, 0, 1000, 0, 0);
        send_volume(CMD_BOX, 0, 0, 0, 999, 999, 999);
        send_volume(CMD_SPHERE, -32768, -32768, -32768, 32767, 0, 0);
        send_volume(CMD_BOX, 32767, 32767, 32767, 32767, 32767, 32767);
        send_volume(CMD_SPHERE, 0, 0, -999, 0, 0, 0);
        send_random_volumes(200, 1000, 1'b1);
        settle_verdicts();

        // Most negative normal component on the left plane; the other planes have zero
        // normals and the largest offset, which ties with the largest sphere radius.
        apb_write(PLANE_LEFT, plane_word(-32768, 0, 0, 0));
        for (int p = PLANE_RIGHT; p <= PLANE_FAR; p++) apb_write(p, plane_word(0, 0, 0, 32767));
        settings_loaded++;
        send_volume(CMD_BOX, -1, 0, 0, 1, 0, 0);
        send_volume(CMD_BOX, 1, 0, 0, 1, 0, 0);
        send_volume(CMD_BOX, -1, 0, 0, 0, 5, 5);
        send_volume(CMD_SPHERE, 0, 0, 0, 32767, 0, 0);
        send_volume(CMD_SPHERE, -1, 0, 0, 2, 0, 0);
        settle_verdicts();

        load_frustum(8000, 3000);
        send_random_volumes(220, 8000, 1'b1);
        settle_verdicts();

        // Long receiver hold-off while requests come back to back, then paced.
        load_frustum(300, 1500);
        hold_request = 1'b1;
        send_random_volumes(80, 300, 1'b0);
        send_random_volumes(120, 300, 1'b1);
        settle_verdicts();

        for (int p = 0; p < PLANE_REGS; p++) apb_write(p, {$urandom, $urandom});
        settings_loaded++;
        send_random_volumes(100, 16000, 1'b1);
        settle_verdicts();

        // Unnormalized and extreme register patterns.
        load_uniform(64'h8000_8000_8000_8000);
        send_random_volumes(34, 32767, 1'b1);
        settle_verdicts();
        load_uniform(64'h7FFF_7FFF_7FFF_7FFF);
        send_random_volumes(33, 32767, 1'b1);
        settle_verdicts();
        load_uniform('1);
        send_random_volumes(33, 32767, 1'b1);
        settle_verdicts();

        $display("Sent %0d volumes under %0d plane settings, including a %0d-cycle output stall.",
                 requests_sent, settings_loaded, HOLD_CYCLES);
        $display("Verdicts returned: %0d inside, %0d intersecting, %0d outside.",
                 inside_seen, intersects_seen, outside_seen);
        if (mismatch_count == 0) begin
            $display("PASS frustum_cull_test");
        end else begin
            $display("FAIL frustum_cull_test");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("Timed out with %0d verdicts still outstanding.", verdicts_pending);
        $display("FAIL frustum_cull_test");
        $finish;
    end

endmodule
